// ----- rtl/ppn_pkg.sv -----
package ppn_pkg;

  // Field and datapath widths
  localparam int ENT_W      = 21;   // one Q12.8 matrix entry
  localparam int ROW_W      = 63;   // three packed entries
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_ROWS   = 6;
  localparam int PT_W       = 24;   // Q15.8 input, Q3.20 output
  localparam int COF_W      = 43;   // Q26.16 cofactor
  localparam int PROD_W     = COF_W + PT_W;   // cofactor times coordinate
  localparam int SUM_W      = PROD_W + 2;     // sum of three products
  localparam int FRAC       = 20;
  localparam int NUM_W      = SUM_W + FRAC;   // dividend magnitude
  localparam int QBITS      = PT_W - 1;       // quotient bits below saturation
  localparam int DIV_STAGES = QBITS;
  localparam int LANE_LAT   = 3 + DIV_STAGES + 1;

  typedef logic signed [COF_W-1:0] cof_t;
  typedef logic signed [PT_W-1:0]  pt_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROW0 = 3'd0,
    REG_A_ROW1 = 3'd1,
    REG_A_ROW2 = 3'd2,
    REG_B_ROW0 = 3'd3,
    REG_B_ROW1 = 3'd4,
    REG_B_ROW2 = 3'd5
  } reg_idx_t;

  // Identity matrix rows after reset
  localparam logic [ROW_W-1:0] ROW0_RST = 63'h0004_0000_0000_0000;
  localparam logic [ROW_W-1:0] ROW1_RST = 63'h0000_0000_2000_0000;
  localparam logic [ROW_W-1:0] ROW2_RST = 63'h0000_0000_0000_0100;

  localparam cof_t COF_ONE = 43'sd65536;
  localparam pt_t  OUT_MAX = 24'sh7FFFFF;
  localparam pt_t  OUT_MIN = 24'sh800000;

  // Per-quotient control bits handed from lane to divider
  typedef struct packed {
    logic neg;
    logic sat;
    logic zero;
  } div_flags_t;

endpackage

// ----- rtl/ppn_in_if.sv -----
interface ppn_in_if;
  import ppn_pkg::*;
  logic valid;
  logic ready;
  pt_t  first_x;
  pt_t  first_y;
  pt_t  second_x;
  pt_t  second_y;
  logic last_match;

  modport source (output valid, first_x, first_y, second_x, second_y, last_match,
                  input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, last_match,
                  output ready);
endinterface

// ----- rtl/ppn_out_if.sv -----
interface ppn_out_if;
  import ppn_pkg::*;
  logic valid;
  logic ready;
  pt_t  first_xn;
  pt_t  first_yn;
  pt_t  second_xn;
  pt_t  second_yn;
  logic degenerate;
  logic last_out;

  modport source (output valid, first_xn, first_yn, second_xn, second_yn, degenerate,
                  last_out, input ready);
  modport sink   (input valid, first_xn, first_yn, second_xn, second_yn, degenerate,
                  last_out, output ready);
endinterface

// ----- rtl/ppn_cofactor.sv -----
module ppn_cofactor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ppn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ppn_pkg::ROW_W-1:0]      cfg_data,
  output ppn_pkg::cof_t                  adj_a [9],
  output ppn_pkg::cof_t                  adj_b [9]
);
  import ppn_pkg::*;

  logic [ROW_W-1:0]        row_r [NUM_ROWS];
  logic signed [ENT_W-1:0] m     [2][3][3];
  cof_t                    adj_nxt [2][9];
  cof_t                    adj_r   [2][9];

  // Camera rows; writes past the last row are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW0_RST;
      row_r[1] <= ROW1_RST;
      row_r[2] <= ROW2_RST;
      row_r[3] <= ROW0_RST;
      row_r[4] <= ROW1_RST;
      row_r[5] <= ROW2_RST;
    end else if (cfg_we && (cfg_idx <= REG_B_ROW2)) begin
      row_r[cfg_idx] <= cfg_data;
    end
  end

  // Unpack entries and form each 2x2 minor
  for (genvar c = 0; c < 2; c++) begin : g_cam
    for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
        assign m[c][i][j] = row_r[3*c+i][ROW_W-1-ENT_W*j -: ENT_W];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_ai
      for (genvar j = 0; j < 3; j++) begin : g_aj
        assign adj_nxt[c][3*i+j] =
            COF_W'(m[c][(j+1)%3][(i+1)%3]) * COF_W'(m[c][(j+2)%3][(i+2)%3])
          - COF_W'(m[c][(j+1)%3][(i+2)%3]) * COF_W'(m[c][(j+2)%3][(i+1)%3]);
      end
    end
  end

  // Cofactor store follows the rows in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 9; k++) begin
          adj_r[c][k] <= (k % 4 == 0) ? COF_ONE : '0;
        end
      end
    end else begin
      adj_r <= adj_nxt;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_out
    assign adj_a[k] = adj_r[0][k];
    assign adj_b[k] = adj_r[1][k];
  end

endmodule

// ----- rtl/ppn_div.sv -----
module ppn_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ppn_pkg::NUM_W-1:0]   num,
  input  logic [ppn_pkg::SUM_W-1:0]   den,
  input  ppn_pkg::div_flags_t         flags,
  output ppn_pkg::pt_t                res,
  output logic                        zero
);
  import ppn_pkg::*;

  localparam int TW = SUM_W + QBITS;

  logic [NUM_W-1:0] rem_r  [DIV_STAGES+1];
  logic [SUM_W-1:0] den_r  [DIV_STAGES+1];
  logic [QBITS-1:0] quo_r  [DIV_STAGES+1];
  div_flags_t       fl_r   [DIV_STAGES+1];
  pt_t              res_r;
  logic             zero_r;

  assign rem_r[0] = num;
  assign den_r[0] = den;
  assign quo_r[0] = '0;
  assign fl_r[0]  = flags;

  // One restoring step per stage, quotient MSB first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int B = QBITS - 1 - s;
    logic [TW-1:0]    diff;
    logic             take;
    logic [QBITS-1:0] quo_nxt;

    always_comb begin
      diff    = TW'(rem_r[s]) - (TW'(den_r[s]) << B);
      take    = ~diff[TW-1];
      quo_nxt = quo_r[s];
      quo_nxt[B] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= take ? diff[NUM_W-1:0] : rem_r[s];
        den_r[s+1] <= den_r[s];
        quo_r[s+1] <= quo_nxt;
        fl_r[s+1]  <= fl_r[s];
      end
    end
  end

  // Apply sign, saturation and the zero-divisor case
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= fl_r[DIV_STAGES].zero;
      if (fl_r[DIV_STAGES].zero)
        res_r <= '0;
      else if (fl_r[DIV_STAGES].sat)
        res_r <= fl_r[DIV_STAGES].neg ? OUT_MIN : OUT_MAX;
      else if (fl_r[DIV_STAGES].neg)
        res_r <= -PT_W'(quo_r[DIV_STAGES]);
      else
        res_r <= PT_W'(quo_r[DIV_STAGES]);
    end
  end

  assign res  = res_r;
  assign zero = zero_r;

endmodule

// ----- rtl/ppn_lane.sv -----
module ppn_lane (
  input  logic          clk,
  input  logic          en,
  input  ppn_pkg::pt_t  px,
  input  ppn_pkg::pt_t  py,
  input  ppn_pkg::cof_t adj [9],
  output ppn_pkg::pt_t  xn,
  output ppn_pkg::pt_t  yn,
  output logic          zero
);
  import ppn_pkg::*;

  logic signed [PROD_W-1:0] prod_r [3][2];
  cof_t                     c2_r   [3];
  logic signed [SUM_W-1:0]  v_r    [3];
  logic [SUM_W-1:0]         mag    [3];
  logic [NUM_W-1:0]         nmag_r [2];
  logic [SUM_W-1:0]         dmag_r;
  div_flags_t               fl_r   [2];
  logic                     zero_x;
  logic                     zero_y;

  // Multiply cofactors by the point; the homogeneous 1 is a shift later
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_r[r][0] <= PROD_W'(adj[3*r])   * PROD_W'(px);
        prod_r[r][1] <= PROD_W'(adj[3*r+1]) * PROD_W'(py);
        c2_r[r]      <= adj[3*r+2];
      end
    end
  end

  // Sum each homogeneous component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        v_r[r] <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                + (SUM_W'(c2_r[r]) <<< 8);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r] = v_r[r][SUM_W-1] ? SUM_W'(-v_r[r]) : SUM_W'(v_r[r]);
    end
  end

  // Split into magnitudes and flags; flag saturation up front
  always_ff @(posedge clk) begin
    if (en) begin
      dmag_r <= mag[2];
      for (int k = 0; k < 2; k++) begin
        nmag_r[k]    <= {mag[k], FRAC'(0)};
        fl_r[k].neg  <= v_r[k][SUM_W-1] ^ v_r[2][SUM_W-1];
        fl_r[k].sat  <= ({3'b000, mag[k]} >= {mag[2], 3'b000});
        fl_r[k].zero <= (v_r[2] == '0);
      end
    end
  end

  ppn_div u_div_x (
    .clk   (clk),
    .en    (en),
    .num   (nmag_r[0]),
    .den   (dmag_r),
    .flags (fl_r[0]),
    .res   (xn),
    .zero  (zero_x)
  );

  ppn_div u_div_y (
    .clk   (clk),
    .en    (en),
    .num   (nmag_r[1]),
    .den   (dmag_r),
    .flags (fl_r[1]),
    .res   (yn),
    .zero  (zero_y)
  );

  // Both dividers carry the same zero-divisor flag
  assign zero = zero_x | zero_y;

endmodule

// ----- rtl/projective_point_normalizer.sv -----
// Channel   Dir  Payload
// in_pt     in   first_x, first_y, second_x, second_y (Q15.8), last_match
// out_res   out  first_xn, first_yn, second_xn, second_yn (Q3.20), degenerate, last_out
// cfg_*     in   cfg_we, cfg_idx (row 0..5), cfg_data (63 bits)
//
// One match is taken per cycle unless the output stalls; each result passes, after its
// transfer in, through multiply, sum, sign split, 23 restoring divider stages, format.
// The two points run in parallel lanes; the divider depth sets the latency.
// A stalled output freezes the whole pipeline; in_pt.ready follows it.
// Synchronous reset clears the valid pipeline and loads identity cameras.
// A register write passes through the row register before it reaches the cofactor store.
module projective_point_normalizer (
  input  logic                           clk,
  input  logic                           rst_n,
  ppn_in_if.sink                         in_pt,
  ppn_out_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [ppn_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ppn_pkg::ROW_W-1:0]      cfg_data
);
  import ppn_pkg::*;

  cof_t adj_a [9];
  cof_t adj_b [9];
  logic adv;
  logic zero_a, zero_b;
  logic vld_r  [LANE_LAT];
  logic last_r [LANE_LAT];

  ppn_cofactor u_cof (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .adj_a    (adj_a),
    .adj_b    (adj_b)
  );

  // Advance unless the output holds a result nobody takes
  assign adv         = out_res.ready || !vld_r[LANE_LAT-1];
  assign in_pt.ready = adv;

  ppn_lane u_lane_a (
    .clk  (clk),
    .en   (adv),
    .px   (in_pt.first_x),
    .py   (in_pt.first_y),
    .adj  (adj_a),
    .xn   (out_res.first_xn),
    .yn   (out_res.first_yn),
    .zero (zero_a)
  );

  ppn_lane u_lane_b (
    .clk  (clk),
    .en   (adv),
    .px   (in_pt.second_x),
    .py   (in_pt.second_y),
    .adj  (adj_b),
    .xn   (out_res.second_xn),
    .yn   (out_res.second_yn),
    .zero (zero_b)
  );

  // Valid and marker travel alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LANE_LAT; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_pt.valid;
      for (int s = 1; s < LANE_LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[0] <= in_pt.last_match;
      for (int s = 1; s < LANE_LAT; s++) last_r[s] <= last_r[s-1];
    end
  end

  // Merge the lanes
  assign out_res.valid      = vld_r[LANE_LAT-1];
  assign out_res.degenerate = zero_a | zero_b;
  assign out_res.last_out   = last_r[LANE_LAT-1];

  a_in_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_pt.valid && in_pt.ready |=> vld_r[0])
    else $error("accepted match missing from pipeline");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.degenerate |->
      (out_res.first_xn == '0 && out_res.first_yn == '0) ||
      (out_res.second_xn == '0 && out_res.second_yn == '0))
    else $error("degenerate result without a zeroed point");

  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LANE_LAT-1] && !out_res.ready |-> !in_pt.ready)
    else $error("input taken while output stalled");

endmodule
